// ===== src/bwsc_pkg.sv =====
// Package for the button wake/sleep controller.
// Holds action, command and press-level codes, register indexes and register reset values.
// No dependencies.
package bwsc_pkg;

    typedef enum logic [2:0] {
        ACT_TICK        = 3'd0,
        ACT_ANSWER      = 3'd1,
        ACT_HOST_TOGGLE = 3'd2,
        ACT_HOST_INPUT1 = 3'd3,
        ACT_HOST_INPUT2 = 3'd4,
        ACT_HOST_WAKE   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_SWITCH      = 3'd1,
        CMD_REBOOT      = 3'd2,
        CMD_FACTORY     = 3'd3,
        CMD_WAKE        = 3'd4,
        CMD_SWITCH_WAKE = 3'd5
    } command_t;

    typedef enum logic [1:0] {
        PRESS_NONE    = 2'd0,
        PRESS_REBOOT  = 2'd1,
        PRESS_FACTORY = 2'd2
    } press_t;

    typedef enum logic [2:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_NOISE        = 3'd1,
        REG_LONG_PRESS   = 3'd2,
        REG_FACTORY      = 3'd3,
        REG_WAKE_WINDOW  = 3'd4,
        REG_POLL_AWAKE   = 3'd5,
        REG_POLL_ASLEEP  = 3'd6,
        REG_SLEEP_DELAY  = 3'd7
    } reg_index_t;

    localparam int unsigned CFG_BITS = 16;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST    = 16'd200;
    localparam logic [CFG_BITS-1:0] NOISE_RST       = 16'd50;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RST  = 16'd3000;
    localparam logic [CFG_BITS-1:0] FACTORY_RST     = 16'd10000;
    localparam logic [CFG_BITS-1:0] WAKE_WINDOW_RST = 16'd2000;
    localparam logic [CFG_BITS-1:0] POLL_AWAKE_RST  = 16'd5000;
    localparam logic [CFG_BITS-1:0] POLL_ASLEEP_RST = 16'd30000;
    localparam logic [CFG_BITS-1:0] SLEEP_DELAY_RST = 16'd10000;

endpackage

// ===== src/button_wake_sleep_controller.sv =====
// Button wake/sleep controller: input register, one-pass step logic, result register.
// Depends on bwsc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item: a 1 ms tick
//   with the button level, a monitor poll answer, or a host request. Output channel
//   (out_valid/out_ready) returns exactly one result transaction per item: command,
//   chosen input, awake flag, poll request, hold preview and wake window status.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the eight
//   16-bit timing registers; it is always ready. Write it only while idle; the block
//   itself does not enforce this. An accepted item passes the input register, then
//   the result register. Throughput: one item per cycle while out_ready holds, set by
//   the combinational state update between the two registers.
//   A stalled output holds its result; the input register still takes one more item,
//   and in_ready drops only once both registers are full.
//   Reset clears all state, loads the register defaults and sets the poll timer to
//   all ones so that the first tick requests a poll.
module button_wake_sleep_controller #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  action,
    input  logic        button_down,
    input  logic        answer_awake,
    input  logic [1:0]  answer_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  command,
    output logic        chosen_input,
    output logic        awake_flag,
    output logic        poll_request,
    output logic [1:0]  press_level,
    output logic        wake_armed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned CW = (TIMER_BITS > bwsc_pkg::CFG_BITS) ?
                                 TIMER_BITS : bwsc_pkg::CFG_BITS;

    typedef logic [TIMER_BITS-1:0]         timer_t;
    typedef logic [bwsc_pkg::CFG_BITS-1:0] cfg_t;

    function automatic timer_t sat_inc(input timer_t t);
        return (t == '1) ? t : t + timer_t'(1);
    endfunction

    function automatic logic ge(input timer_t t, input cfg_t c);
        return CW'(t) >= CW'(c);
    endfunction

    function automatic logic gt(input timer_t t, input cfg_t c);
        return CW'(t) > CW'(c);
    endfunction

    cfg_t debounce_reg, noise_reg, long_press_reg, factory_reg;
    cfg_t wake_window_reg, poll_awake_reg, poll_asleep_reg, sleep_delay_reg;

    logic       s1_valid_reg;
    logic [2:0] s1_action_reg;
    logic       s1_down_reg;
    logic       s1_awake_reg;
    logic [1:0] s1_input_reg;

    logic       out_valid_reg;
    logic [2:0] command_reg;
    logic       chosen_reg;
    logic       awake_out_reg;
    logic       poll_reg;
    logic [1:0] press_reg;
    logic       armed_reg;

    logic       btn_held_reg, btn_held_next;
    timer_t     hold_timer_reg, hold_timer_next;
    logic [1:0] preview_reg, preview_next;
    timer_t     since_tap_reg, since_tap_next;
    logic       window_open_reg, window_open_next;
    timer_t     window_timer_reg, window_timer_next;
    logic       input_at_arm_reg, input_at_arm_next;
    logic       selected_reg, selected_next;
    logic       awake_state_reg, awake_state_next;
    timer_t     poll_timer_reg, poll_timer_next;
    logic       off_seen_reg, off_seen_next;
    timer_t     off_timer_reg, off_timer_next;

    logic [2:0] cmd;
    logic       poll;
    logic       advance;
    cfg_t       interval;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= bwsc_pkg::DEBOUNCE_RST;
            noise_reg       <= bwsc_pkg::NOISE_RST;
            long_press_reg  <= bwsc_pkg::LONG_PRESS_RST;
            factory_reg     <= bwsc_pkg::FACTORY_RST;
            wake_window_reg <= bwsc_pkg::WAKE_WINDOW_RST;
            poll_awake_reg  <= bwsc_pkg::POLL_AWAKE_RST;
            poll_asleep_reg <= bwsc_pkg::POLL_ASLEEP_RST;
            sleep_delay_reg <= bwsc_pkg::SLEEP_DELAY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bwsc_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg_data;
                bwsc_pkg::REG_NOISE:       noise_reg       <= cfg_data;
                bwsc_pkg::REG_LONG_PRESS:  long_press_reg  <= cfg_data;
                bwsc_pkg::REG_FACTORY:     factory_reg     <= cfg_data;
                bwsc_pkg::REG_WAKE_WINDOW: wake_window_reg <= cfg_data;
                bwsc_pkg::REG_POLL_AWAKE:  poll_awake_reg  <= cfg_data;
                bwsc_pkg::REG_POLL_ASLEEP: poll_asleep_reg <= cfg_data;
                bwsc_pkg::REG_SLEEP_DELAY: sleep_delay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_action_reg <= action;
            s1_down_reg   <= button_down;
            s1_awake_reg  <= answer_awake;
            s1_input_reg  <= answer_input;
        end
    end

    // Step logic
    always_comb
    begin
        btn_held_next     = btn_held_reg;
        hold_timer_next   = hold_timer_reg;
        preview_next      = preview_reg;
        since_tap_next    = since_tap_reg;
        window_open_next  = window_open_reg;
        window_timer_next = window_timer_reg;
        input_at_arm_next = input_at_arm_reg;
        selected_next     = selected_reg;
        awake_state_next  = awake_state_reg;
        poll_timer_next   = poll_timer_reg;
        off_seen_next     = off_seen_reg;
        off_timer_next    = off_timer_reg;
        cmd               = bwsc_pkg::CMD_NONE;
        poll              = 1'b0;
        interval          = awake_state_reg ? poll_awake_reg : poll_asleep_reg;

        case (s1_action_reg)
            bwsc_pkg::ACT_TICK:
            begin
                if (btn_held_reg)
                begin
                    hold_timer_next = sat_inc(hold_timer_reg);
                end
                since_tap_next  = sat_inc(since_tap_reg);
                if (window_open_reg)
                begin
                    window_timer_next = sat_inc(window_timer_reg);
                end
                poll_timer_next = sat_inc(poll_timer_reg);
                if (off_seen_reg)
                begin
                    off_timer_next = sat_inc(off_timer_reg);
                end

                if (s1_down_reg && !btn_held_reg)
                begin
                    btn_held_next   = 1'b1;
                    hold_timer_next = '0;
                    preview_next    = bwsc_pkg::PRESS_NONE;
                end
                else if (s1_down_reg && btn_held_reg)
                begin
                    if (ge(hold_timer_next, factory_reg) &&
                        preview_reg != bwsc_pkg::PRESS_FACTORY)
                    begin
                        preview_next = bwsc_pkg::PRESS_FACTORY;
                    end
                    else if (ge(hold_timer_next, long_press_reg) &&
                             preview_reg == bwsc_pkg::PRESS_NONE)
                    begin
                        preview_next = bwsc_pkg::PRESS_REBOOT;
                    end
                end
                else if (!s1_down_reg && btn_held_reg)
                begin
                    btn_held_next = 1'b0;
                    if (ge(hold_timer_next, factory_reg))
                    begin
                        cmd = bwsc_pkg::CMD_FACTORY;
                    end
                    else if (ge(hold_timer_next, long_press_reg))
                    begin
                        cmd = bwsc_pkg::CMD_REBOOT;
                    end
                    else if (gt(hold_timer_next, noise_reg) &&
                             gt(since_tap_next, debounce_reg))
                    begin
                        since_tap_next = '0;
                        if (!awake_state_reg)
                        begin
                            if (!window_open_reg)
                            begin
                                window_open_next  = 1'b1;
                                input_at_arm_next = selected_reg;
                            end
                            else
                            begin
                                selected_next = ~selected_reg;
                            end
                            window_timer_next = '0;
                        end
                        else
                        begin
                            selected_next = ~selected_reg;
                            cmd           = bwsc_pkg::CMD_SWITCH;
                        end
                    end
                    preview_next = bwsc_pkg::PRESS_NONE;
                end

                if (window_open_next && cmd == bwsc_pkg::CMD_NONE &&
                    ge(window_timer_next, wake_window_reg))
                begin
                    window_open_next = 1'b0;
                    cmd = (selected_next != input_at_arm_next) ?
                          bwsc_pkg::CMD_SWITCH_WAKE : bwsc_pkg::CMD_WAKE;
                end

                if (ge(poll_timer_next, interval))
                begin
                    poll            = 1'b1;
                    poll_timer_next = '0;
                end
            end
            bwsc_pkg::ACT_ANSWER:
            begin
                if (s1_awake_reg && !awake_state_reg)
                begin
                    awake_state_next = 1'b1;
                    off_seen_next    = 1'b0;
                    if (s1_input_reg == 2'd1)
                    begin
                        selected_next = 1'b0;
                    end
                    else if (s1_input_reg == 2'd2)
                    begin
                        selected_next = 1'b1;
                    end
                end
                else if (!s1_awake_reg && awake_state_reg)
                begin
                    if (!off_seen_reg)
                    begin
                        off_seen_next  = 1'b1;
                        off_timer_next = '0;
                    end
                    else if (ge(off_timer_reg, sleep_delay_reg))
                    begin
                        awake_state_next = 1'b0;
                        off_seen_next    = 1'b0;
                    end
                end
                else if (s1_awake_reg)
                begin
                    off_seen_next = 1'b0;
                end
            end
            bwsc_pkg::ACT_HOST_TOGGLE:
            begin
                selected_next = ~selected_reg;
                cmd           = bwsc_pkg::CMD_SWITCH;
            end
            bwsc_pkg::ACT_HOST_INPUT1:
            begin
                if (selected_reg)
                begin
                    selected_next = 1'b0;
                    cmd           = bwsc_pkg::CMD_SWITCH;
                end
            end
            bwsc_pkg::ACT_HOST_INPUT2:
            begin
                if (!selected_reg)
                begin
                    selected_next = 1'b1;
                    cmd           = bwsc_pkg::CMD_SWITCH;
                end
            end
            bwsc_pkg::ACT_HOST_WAKE:
            begin
                cmd = bwsc_pkg::CMD_WAKE;
            end
            default: ;
        endcase
    end

    // State and result registers, advance on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_held_reg     <= 1'b0;
            hold_timer_reg   <= '0;
            preview_reg      <= bwsc_pkg::PRESS_NONE;
            since_tap_reg    <= '0;
            window_open_reg  <= 1'b0;
            window_timer_reg <= '0;
            input_at_arm_reg <= 1'b0;
            selected_reg     <= 1'b0;
            awake_state_reg  <= 1'b0;
            poll_timer_reg   <= '1;
            off_seen_reg     <= 1'b0;
            off_timer_reg    <= '0;
        end
        else if (advance)
        begin
            btn_held_reg     <= btn_held_next;
            hold_timer_reg   <= hold_timer_next;
            preview_reg      <= preview_next;
            since_tap_reg    <= since_tap_next;
            window_open_reg  <= window_open_next;
            window_timer_reg <= window_timer_next;
            input_at_arm_reg <= input_at_arm_next;
            selected_reg     <= selected_next;
            awake_state_reg  <= awake_state_next;
            poll_timer_reg   <= poll_timer_next;
            off_seen_reg     <= off_seen_next;
            off_timer_reg    <= off_timer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            command_reg   <= cmd;
            chosen_reg    <= selected_next;
            awake_out_reg <= awake_state_next;
            poll_reg      <= poll;
            press_reg     <= preview_next;
            armed_reg     <= window_open_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command      = command_reg;
    assign chosen_input = chosen_reg;
    assign awake_flag   = awake_out_reg;
    assign poll_request = poll_reg;
    assign press_level  = press_reg;
    assign wake_armed   = armed_reg;

endmodule

// ===== tb/button_wake_sleep_controller_tb.sv =====
// Self-checking testbench for button_wake_sleep_controller: directed and random item traffic,
// timing register sweeps and random idling on both channels against an in-bench predictor.
// Depends on bwsc_pkg and the button_wake_sleep_controller RTL.
module button_wake_sleep_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 165;
    localparam int LONG_HOLD_OFF = 80;
    localparam int QUIET_LIMIT   = 2000;

    typedef enum {TIMING_MAX, TIMING_MIN, TIMING_DEFAULT, TIMING_RANDOM} timing_mix_t;

    typedef struct packed {
        logic [2:0] act;
        logic       down;
        logic       aw;
        logic [1:0] inp;
    } controller_item_t;

    typedef struct packed {
        bwsc_pkg::command_t cmd;
        logic               chosen;
        logic               awake;
        logic               poll;
        bwsc_pkg::press_t   level;
        logic               armed;
    } controller_result_t;

    class wake_sleep_scoreboard;
        logic [15:0] timing [8];
        bit          held, win_open, arm_input, sel, awake, off_pending;
        logic [15:0] hold_t, since_tap, win_t, poll_t, off_t;
        bwsc_pkg::press_t preview;
        controller_result_t pending_outcomes [$];
        int items_seen, results_checked, errors, polls;
        int cmd_tally [6];

        function new();
            timing[bwsc_pkg::REG_DEBOUNCE]    = bwsc_pkg::DEBOUNCE_RST;
            timing[bwsc_pkg::REG_NOISE]       = bwsc_pkg::NOISE_RST;
            timing[bwsc_pkg::REG_LONG_PRESS]  = bwsc_pkg::LONG_PRESS_RST;
            timing[bwsc_pkg::REG_FACTORY]     = bwsc_pkg::FACTORY_RST;
            timing[bwsc_pkg::REG_WAKE_WINDOW] = bwsc_pkg::WAKE_WINDOW_RST;
            timing[bwsc_pkg::REG_POLL_AWAKE]  = bwsc_pkg::POLL_AWAKE_RST;
            timing[bwsc_pkg::REG_POLL_ASLEEP] = bwsc_pkg::POLL_ASLEEP_RST;
            timing[bwsc_pkg::REG_SLEEP_DELAY] = bwsc_pkg::SLEEP_DELAY_RST;
            held = 0; win_open = 0; arm_input = 0; sel = 0; awake = 0; off_pending = 0;
            hold_t = 0; since_tap = 0; win_t = 0; poll_t = 16'hFFFF; off_t = 0;
            preview = bwsc_pkg::PRESS_NONE;
            items_seen = 0; results_checked = 0; errors = 0; polls = 0;
            foreach (cmd_tally[i]) cmd_tally[i] = 0;
        endfunction

        function void set_timing(logic [2:0] idx, logic [15:0] val);
            timing[idx] = val;
        endfunction

        function logic [15:0] bump(logic [15:0] t);
            return (t == 16'hFFFF) ? t : t + 16'd1;
        endfunction

        function void note_item(controller_item_t it);
            controller_result_t r;
            bwsc_pkg::command_t c;
            logic        poll;
            logic [15:0] interval;
            c = bwsc_pkg::CMD_NONE;
            poll = 1'b0;
            case (it.act)
                bwsc_pkg::ACT_TICK: begin
                    if (held) hold_t = bump(hold_t);
                    since_tap = bump(since_tap);
                    if (win_open) win_t = bump(win_t);
                    poll_t = bump(poll_t);
                    if (off_pending) off_t = bump(off_t);

                    if (it.down && !held) begin
                        held = 1;
                        hold_t = 0;
                        preview = bwsc_pkg::PRESS_NONE;
                    end else if (it.down && held) begin
                        if (hold_t >= timing[bwsc_pkg::REG_FACTORY]
                            && preview != bwsc_pkg::PRESS_FACTORY)
                            preview = bwsc_pkg::PRESS_FACTORY;
                        else if (hold_t >= timing[bwsc_pkg::REG_LONG_PRESS]
                                 && preview == bwsc_pkg::PRESS_NONE)
                            preview = bwsc_pkg::PRESS_REBOOT;
                    end else if (!it.down && held) begin
                        held = 0;
                        if (hold_t >= timing[bwsc_pkg::REG_FACTORY]) begin
                            c = bwsc_pkg::CMD_FACTORY;
                        end else if (hold_t >= timing[bwsc_pkg::REG_LONG_PRESS]) begin
                            c = bwsc_pkg::CMD_REBOOT;
                        end else if (hold_t > timing[bwsc_pkg::REG_NOISE]
                                     && since_tap > timing[bwsc_pkg::REG_DEBOUNCE]) begin
                            since_tap = 0;
                            if (!awake) begin
                                if (!win_open) begin
                                    win_open = 1;
                                    arm_input = sel;
                                end else begin
                                    sel = ~sel;
                                end
                                win_t = 0;
                            end else begin
                                sel = ~sel;
                                c = bwsc_pkg::CMD_SWITCH;
                            end
                        end
                        preview = bwsc_pkg::PRESS_NONE;
                    end

                    if (win_open && c == bwsc_pkg::CMD_NONE
                        && win_t >= timing[bwsc_pkg::REG_WAKE_WINDOW]) begin
                        win_open = 0;
                        c = (sel != arm_input) ? bwsc_pkg::CMD_SWITCH_WAKE
                                               : bwsc_pkg::CMD_WAKE;
                    end

                    interval = awake ? timing[bwsc_pkg::REG_POLL_AWAKE]
                                     : timing[bwsc_pkg::REG_POLL_ASLEEP];
                    if (poll_t >= interval) begin
                        poll = 1'b1;
                        poll_t = 0;
                    end
                end
                bwsc_pkg::ACT_ANSWER: begin
                    if (it.aw && !awake) begin
                        awake = 1;
                        off_pending = 0;
                        if (it.inp == 2'd1) sel = 0;
                        else if (it.inp == 2'd2) sel = 1;
                    end else if (!it.aw && awake) begin
                        if (!off_pending) begin
                            off_pending = 1;
                            off_t = 0;
                        end else if (off_t >= timing[bwsc_pkg::REG_SLEEP_DELAY]) begin
                            awake = 0;
                            off_pending = 0;
                        end
                    end else if (it.aw) begin
                        off_pending = 0;
                    end
                end
                bwsc_pkg::ACT_HOST_TOGGLE: begin
                    sel = ~sel;
                    c = bwsc_pkg::CMD_SWITCH;
                end
                bwsc_pkg::ACT_HOST_INPUT1: begin
                    if (sel) begin
                        sel = 0;
                        c = bwsc_pkg::CMD_SWITCH;
                    end
                end
                bwsc_pkg::ACT_HOST_INPUT2: begin
                    if (!sel) begin
                        sel = 1;
                        c = bwsc_pkg::CMD_SWITCH;
                    end
                end
                bwsc_pkg::ACT_HOST_WAKE: c = bwsc_pkg::CMD_WAKE;
                default: ;
            endcase
            r.cmd    = c;
            r.chosen = sel;
            r.awake  = awake;
            r.poll   = poll;
            r.level  = preview;
            r.armed  = win_open;
            pending_outcomes.push_back(r);
            items_seen++;
            cmd_tally[c]++;
            if (poll) polls++;
        endfunction

        function void flag(string field, logic [2:0] want, logic [2:0] got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(controller_result_t got);
            controller_result_t want;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with none expected, command %0d", $time, got.cmd);
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            results_checked++;
            if (got.cmd !== want.cmd)       flag("command", want.cmd, got.cmd);
            if (got.chosen !== want.chosen) flag("chosen_input", want.chosen, got.chosen);
            if (got.awake !== want.awake)   flag("awake_flag", want.awake, got.awake);
            if (got.poll !== want.poll)     flag("poll_request", want.poll, got.poll);
            if (got.level !== want.level)   flag("press_level", want.level, got.level);
            if (got.armed !== want.armed)   flag("wake_armed", want.armed, got.armed);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  action;
    logic        button_down;
    logic        answer_awake;
    logic [1:0]  answer_input;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  command;
    logic        chosen_input;
    logic        awake_flag;
    logic        poll_request;
    logic [1:0]  press_level;
    logic        wake_armed;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    wake_sleep_scoreboard sb = new();

    logic [15:0] plan [8];
    logic [15:0] timing_now [8];
    int  burst_left = 0;
    int  items_offered = 0;
    int  settings_used = 0;
    int  quiet_cycles = 0;
    bit  hold_off_pending = 1'b0;

    button_wake_sleep_controller #(.TIMER_BITS(16)) dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_item('{action, button_down, answer_awake, answer_input});
            if (out_valid && out_ready)
                sb.check_result('{bwsc_pkg::command_t'(command), chosen_input, awake_flag,
                                  poll_request, bwsc_pkg::press_t'(press_level), wake_armed});
            if (cfg_valid && cfg_ready)
                sb.set_timing(cfg_index, cfg_data);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : receiver
        int stall_left, mode_left, ready_mode, beat;
        stall_left = 0;
        mode_left = 0;
        ready_mode = 0;
        beat = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            beat++;
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                stall_left = LONG_HOLD_OFF;
                out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (ready_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (beat % 3) != 0;
                    default: out_ready <= (beat % 8) < 2;
                endcase
            end
        end
    end

    function automatic int capped(logic [15:0] v, int lim);
        return (v > lim) ? lim : int'(v);
    endfunction

    function automatic int hold_length();
        int h;
        case ($urandom_range(0, 3))
            0: h = capped(timing_now[bwsc_pkg::REG_NOISE], 40);
            1: h = capped(timing_now[bwsc_pkg::REG_LONG_PRESS], 40);
            2: h = capped(timing_now[bwsc_pkg::REG_FACTORY], 40);
            default: h = int'($urandom_range(1, 30));
        endcase
        h = h + int'($urandom_range(0, 2)) - 1;
        return (h < 1) ? 1 : h;
    endfunction

    function automatic void choose_timing(timing_mix_t mix);
        logic [15:0] swap;
        case (mix)
            TIMING_MAX: foreach (plan[i]) plan[i] = 16'hFFFF;
            TIMING_MIN: begin
                foreach (plan[i]) plan[i] = 16'd0;
                plan[bwsc_pkg::REG_POLL_AWAKE]  = 16'd1;
                plan[bwsc_pkg::REG_POLL_ASLEEP] = 16'd1;
            end
            TIMING_DEFAULT: plan = '{bwsc_pkg::DEBOUNCE_RST, bwsc_pkg::NOISE_RST,
                                     bwsc_pkg::LONG_PRESS_RST, bwsc_pkg::FACTORY_RST,
                                     bwsc_pkg::WAKE_WINDOW_RST, bwsc_pkg::POLL_AWAKE_RST,
                                     bwsc_pkg::POLL_ASLEEP_RST, bwsc_pkg::SLEEP_DELAY_RST};
            default: begin
                plan[bwsc_pkg::REG_DEBOUNCE]    = 16'($urandom_range(0, 8));
                plan[bwsc_pkg::REG_NOISE]       = 16'($urandom_range(0, 4));
                plan[bwsc_pkg::REG_LONG_PRESS]  = plan[bwsc_pkg::REG_NOISE]
                                                  + 16'($urandom_range(1, 10));
                plan[bwsc_pkg::REG_FACTORY]     = plan[bwsc_pkg::REG_LONG_PRESS]
                                                  + 16'($urandom_range(0, 10));
                plan[bwsc_pkg::REG_WAKE_WINDOW] = 16'($urandom_range(0, 12));
                plan[bwsc_pkg::REG_POLL_AWAKE]  = 16'($urandom_range(1, 15));
                plan[bwsc_pkg::REG_POLL_ASLEEP] = 16'($urandom_range(1, 20));
                plan[bwsc_pkg::REG_SLEEP_DELAY] = 16'($urandom_range(0, 10));
                if ($urandom_range(0, 4) == 0) begin
                    swap = plan[bwsc_pkg::REG_LONG_PRESS];
                    plan[bwsc_pkg::REG_LONG_PRESS] = plan[bwsc_pkg::REG_FACTORY];
                    plan[bwsc_pkg::REG_FACTORY] = swap;
                end
                if ($urandom_range(0, 5) == 0)
                    plan[3'($urandom_range(0, 7))] = 16'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    task automatic offer(logic [2:0] act, logic down, logic aw, logic [1:0] inp);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(1, 25);
        end
        burst_left--;
        in_valid     <= 1'b1;
        action       <= act;
        button_down  <= down;
        answer_awake <= aw;
        answer_input <= inp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_offered++;
    endtask

    task automatic send_tick(logic down);
        offer(bwsc_pkg::ACT_TICK, down, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endtask

    task automatic send_answer(logic aw, logic [1:0] inp);
        offer(bwsc_pkg::ACT_ANSWER, 1'($urandom_range(0, 1)), aw, inp);
    endtask

    task automatic send_host(logic [2:0] act);
        offer(act, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              2'($urandom_range(0, 3)));
    endtask

    task automatic idle_ticks(int n);
        repeat (n) send_tick(1'b0);
    endtask

    task automatic press_button(int n);
        repeat (n) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending_outcomes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_timing();
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= bwsc_pkg::reg_index_t'(i);
            cfg_data  <= plan[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            timing_now[i] = plan[i];
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_traffic(int quota, bit squeeze);
        int first, pick;
        first = items_offered;
        while (items_offered - first < quota) begin
            if (squeeze && items_offered - first >= quota / 2) begin
                hold_off_pending = 1'b1;
                squeeze = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                press_button(hold_length());
            end else if (pick < 50) begin
                idle_ticks(capped(timing_now[bwsc_pkg::REG_DEBOUNCE], 30) + 1);
                press_button(capped(timing_now[bwsc_pkg::REG_NOISE], 40) + 1
                             + int'($urandom_range(0, 1)));
                if ($urandom_range(0, 1))
                    idle_ticks(capped(timing_now[bwsc_pkg::REG_WAKE_WINDOW], 30) + 1);
            end else if (pick < 63) begin
                idle_ticks($urandom_range(1, 12));
            end else if (pick < 76) begin
                send_answer(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            end else if (pick < 84) begin
                send_answer(1'b0, 2'($urandom_range(0, 3)));
                idle_ticks(capped(timing_now[bwsc_pkg::REG_SLEEP_DELAY], 30) + 1);
                send_answer(1'b0, 2'($urandom_range(0, 3)));
            end else if (pick < 93) begin
                send_host(3'($urandom_range(bwsc_pkg::ACT_HOST_TOGGLE,
                                            bwsc_pkg::ACT_HOST_WAKE)));
            end else if ($urandom_range(0, 1)) begin
                send_host($urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI);
            end else begin
                send_tick(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = bwsc_pkg::ACT_TICK;
        button_down  = 1'b0;
        answer_awake = 1'b0;
        answer_input = 2'd0;
        cfg_valid    = 1'b0;
        cfg_index    = bwsc_pkg::REG_DEBOUNCE;
        cfg_data     = 16'd0;
        timing_now   = '{bwsc_pkg::DEBOUNCE_RST, bwsc_pkg::NOISE_RST,
                         bwsc_pkg::LONG_PRESS_RST, bwsc_pkg::FACTORY_RST,
                         bwsc_pkg::WAKE_WINDOW_RST, bwsc_pkg::POLL_AWAKE_RST,
                         bwsc_pkg::POLL_ASLEEP_RST, bwsc_pkg::SLEEP_DELAY_RST};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: saturated poll timer, host requests, unused codes, answers
        send_tick(1'b0);
        send_host(bwsc_pkg::ACT_HOST_TOGGLE);
        send_host(bwsc_pkg::ACT_HOST_INPUT2);
        send_host(bwsc_pkg::ACT_HOST_INPUT1);
        send_host(bwsc_pkg::ACT_HOST_INPUT1);
        send_host(bwsc_pkg::ACT_HOST_INPUT2);
        send_host(bwsc_pkg::ACT_HOST_WAKE);
        offer(ACT_SPARE_LO, 1'b0, 1'b0, 2'd0);
        offer(ACT_SPARE_HI, 1'b1, 1'b1, 2'd3);
        send_answer(1'b1, 2'd3);
        send_answer(1'b0, 2'd0);
        send_answer(1'b0, 2'd1);
        send_answer(1'b1, 2'd0);

        // zero thresholds and window: immediate sleep, wake fired on the arming tick
        settle_block();
        plan = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd1, 16'd0};
        load_timing();
        send_answer(1'b0, 2'd2);
        send_answer(1'b0, 2'd0);
        press_button(1);
        send_answer(1'b1, 2'd1);
        press_button(1);

        for (int p = 0; p < PHASES; p++) begin
            settle_block();
            choose_timing(p == 1 ? TIMING_MAX : p == 3 ? TIMING_MIN :
                          p == 5 ? TIMING_DEFAULT : TIMING_RANDOM);
            load_timing();
            run_traffic(PHASE_ITEMS, p == 2 || p == 6);
        end

        settle_block();
        repeat (6) @(posedge clk);

        $display("Ran %0d items under %0d timing settings, %0d results checked, %0d polls.",
                 sb.items_seen, settings_used, sb.results_checked, sb.polls);
        $display("Commands seen: switch %0d, reboot %0d, factory %0d, wake %0d, switch+wake %0d.",
                 sb.cmd_tally[bwsc_pkg::CMD_SWITCH], sb.cmd_tally[bwsc_pkg::CMD_REBOOT],
                 sb.cmd_tally[bwsc_pkg::CMD_FACTORY], sb.cmd_tally[bwsc_pkg::CMD_WAKE],
                 sb.cmd_tally[bwsc_pkg::CMD_SWITCH_WAKE]);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
